>>> rtl/core/tcw_pkg.sv
// tcw_pkg: types, constants and helpers shared by the text console writer
// depends on nothing; imported by tcw_front, tcw_back and the top level
package tcw_pkg;

  // screen geometry
  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int NCELLS = COLS * ROWS;
  localparam int ADDR_W = $clog2(NCELLS);

  // field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CH_W   = 8;
  localparam int LIN_W  = 11;

  // character codes
  localparam logic [CH_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CH_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CH_W-1:0] CH_ESCAPE    = 8'd27;
  localparam logic [CH_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [CH_W-1:0] RESET_COLOUR = 8'h07;

  // item kinds
  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_PLACE = 2'd2;

  // operations handed from front to back
  localparam logic [2:0] OP_CHAR    = 3'd0;
  localparam logic [2:0] OP_NEWLINE = 3'd1;
  localparam logic [2:0] OP_BACK    = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;
  localparam logic [2:0] OP_PLACE   = 3'd5;
  localparam logic [2:0] OP_NONE    = 3'd6;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CH_W-1:0]  char_code;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } in_t;

  typedef struct packed {
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic [LIN_W-1:0] cursor_linear;
    logic [CH_W-1:0]  read_char;
    logic [CH_W-1:0]  read_attr;
  } out_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [CH_W-1:0]   ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  // cell index of a screen position
  function automatic logic [ADDR_W-1:0] linear(input logic [COL_W-1:0] c,
                                               input logic [ROW_W-1:0] r);
    return ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
  endfunction

endpackage

>>> rtl/core/tcw_front.sv
// tcw_front: accepts items, clamps coordinates, decodes them into operations
// and holds them in a two-entry queue for the back end; uses tcw_pkg
module tcw_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  tcw_pkg::in_t  in_data,
  input  logic          hold,
  output logic          cmd_valid,
  output tcw_pkg::cmd_t cmd,
  input  logic          cmd_take
);
  import tcw_pkg::*;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  cmd_t             cmd_in;
  logic [COL_W-1:0] col_c;
  logic [ROW_W-1:0] row_c;
  logic             accept;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  // clamp and decode
  always_comb begin
    col_c = (in_data.col > COL_LAST) ? COL_LAST : in_data.col;
    row_c = (in_data.row > ROW_LAST) ? ROW_LAST : in_data.row;
    cmd_in.ch   = in_data.char_code;
    cmd_in.col  = col_c;
    cmd_in.row  = row_c;
    cmd_in.addr = linear(col_c, row_c);
    unique case (in_data.kind)
      KIND_PUT: begin
        unique case (in_data.char_code)
          CH_NEWLINE:   cmd_in.op = OP_NEWLINE;
          CH_BACKSPACE: cmd_in.op = OP_BACK;
          CH_ESCAPE:    cmd_in.op = OP_CLEAR;
          default:      cmd_in.op = OP_CHAR;
        endcase
      end
      KIND_READ:  cmd_in.op = OP_READ;
      KIND_PLACE: cmd_in.op = OP_PLACE;
      default:    cmd_in.op = OP_NONE;
    endcase
  end

  // queue handshake
  assign full      = (count == 2'd2) || hold;
  assign accept    = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({accept, cmd_take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= cmd_in;
    end
  end

endmodule

>>> rtl/core/tcw_back.sv
// tcw_back: screen store, cursor and the sequencer that carries out
// operations, including clear and scroll sweeps; uses tcw_pkg
module tcw_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  tcw_pkg::cmd_t         cmd,
  output logic                  cmd_take,
  input  logic [tcw_pkg::CH_W-1:0] text_colour,
  output logic                  clearing,
  output logic                  empty,
  input  logic                  pop,
  output tcw_pkg::out_t         out_data
);
  import tcw_pkg::*;

  localparam logic [1:0] ST_FILL   = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_READ   = 2'd2;
  localparam logic [1:0] ST_SCROLL = 2'd3;

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(NCELLS - 1);
  localparam logic [ADDR_W-1:0] SCROLL_END = ADDR_W'((ROWS - 1) * COLS);
  localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLS);
  localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);

  logic [15:0] mem [NCELLS];
  logic [15:0] rd_cell;

  logic [1:0]        state, state_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  logic              fill_reply, fill_reply_next;
  logic              init_done, init_done_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic              res_valid;
  out_t              res, res_next;
  logic              res_set;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [15:0]       mem_wdata;
  logic [15:0]       blank;
  logic [ADDR_W-1:0] pos;
  logic              slot_free;
  logic [CH_W-1:0]   rd_char;
  logic [CH_W-1:0]   rd_attr;

  assign blank     = {text_colour, CH_SPACE};
  assign pos       = linear(cur_col, cur_row);
  assign slot_free = !res_valid || pop;

  // sequencer
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    fill_reply_next = fill_reply;
    init_done_next  = init_done;
    cur_col_next    = cur_col;
    cur_row_next    = cur_row;
    mem_we          = 1'b0;
    mem_waddr       = pos;
    mem_wdata       = blank;
    mem_raddr       = cmd.addr;
    cmd_take        = 1'b0;
    res_set         = 1'b0;
    rd_char         = '0;
    rd_attr         = '0;
    unique case (state)
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        if (cnt == LAST_CELL) begin
          state_next     = ST_IDLE;
          init_done_next = 1'b1;
          res_set        = fill_reply;
        end else begin
          cnt_next = cnt + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_take = 1'b1;
          res_set  = 1'b1;
          unique case (cmd.op)
            OP_CHAR, OP_NEWLINE: begin
              if (cmd.op == OP_CHAR) begin
                mem_we    = 1'b1;
                mem_wdata = {text_colour, cmd.ch};
              end
              if (cmd.op == OP_CHAR && cur_col != COL_LAST) begin
                cur_col_next = cur_col + COL_W'(1);
              end else begin
                cur_col_next = '0;
                if (cur_row == ROW_LAST) begin
                  // bottom row: scroll before replying
                  state_next = ST_SCROLL;
                  cnt_next   = '0;
                  res_set    = 1'b0;
                end else begin
                  cur_row_next = cur_row + ROW_W'(1);
                end
              end
            end
            OP_BACK: begin
              if (cur_col != '0 || cur_row != '0) begin
                mem_we    = 1'b1;
                mem_waddr = pos - ADDR_W'(1);
                if (cur_col == '0) begin
                  cur_col_next = COL_LAST;
                  cur_row_next = cur_row - ROW_W'(1);
                end else begin
                  cur_col_next = cur_col - COL_W'(1);
                end
              end
            end
            OP_CLEAR: begin
              cur_col_next    = '0;
              cur_row_next    = '0;
              state_next      = ST_FILL;
              cnt_next        = '0;
              fill_reply_next = 1'b1;
              res_set         = 1'b0;
            end
            OP_READ: begin
              state_next = ST_READ;
              res_set    = 1'b0;
            end
            OP_PLACE: begin
              cur_col_next = cmd.col;
              cur_row_next = cmd.row;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        res_set    = 1'b1;
        rd_char    = rd_cell[7:0];
        rd_attr    = rd_cell[15:8];
        state_next = ST_IDLE;
      end
      ST_SCROLL: begin
        // copy cell k+COLS to k, one read ahead of the write
        mem_raddr = (cnt == SCROLL_END) ? '0 : cnt + ROW_STEP;
        if (cnt != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cnt - ADDR_W'(1);
          mem_wdata = rd_cell;
        end
        if (cnt == SCROLL_END) begin
          // blank the bottom row next
          state_next      = ST_FILL;
          fill_reply_next = 1'b1;
        end else begin
          cnt_next = cnt + ADDR_W'(1);
        end
      end
    endcase
    res_next.cursor_col    = cur_col_next;
    res_next.cursor_row    = cur_row_next;
    res_next.cursor_linear = LIN_W'(linear(cur_col_next, cur_row_next));
    res_next.read_char     = rd_char;
    res_next.read_attr     = rd_attr;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL;
      cnt        <= '0;
      fill_reply <= 1'b0;
      init_done  <= 1'b0;
      cur_col    <= '0;
      cur_row    <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      fill_reply <= fill_reply_next;
      init_done  <= init_done_next;
      cur_col    <= cur_col_next;
      cur_row    <= cur_row_next;
      if (res_set) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_set) begin
      res <= res_next;
    end
  end

  // screen store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_cell <= mem[mem_raddr];
  end

  assign clearing = !init_done;
  assign empty    = !res_valid;
  assign out_data = res;

endmodule

>>> rtl/core/text_console_writer_core.sv
// text_console_writer_core: top level of the text console writer
// holds the colour register and joins tcw_front and tcw_back; uses tcw_pkg
//
//   channel   ports                        moves
//   input     push, full, in_data          one put/read/place item
//   result    pop, empty, out_data         cursor and read cell per item
//   config    cfg_we, cfg_data             text colour byte
//
// The back end takes one item per cycle for character, backspace, place and
// unused kinds while the result register is free or being popped; a read
// first waits for the registered store read. A newline or wrap on the bottom
// row scrolls: each row but the top is copied up one row, then the bottom
// row is blanked. Escape sweeps all ROWS*COLS cells. After reset a clearing
// pass over all ROWS*COLS cells keeps full high. A two-entry queue between
// front and back and the result register let input and output stall independently.
module text_console_writer_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  tcw_pkg::in_t              in_data,
  output logic                      empty,
  input  logic                      pop,
  output tcw_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  logic [tcw_pkg::CH_W-1:0]  cfg_data
);
  import tcw_pkg::*;

  logic [CH_W-1:0] text_colour;
  logic            clearing;
  logic            cmd_valid;
  cmd_t            cmd;
  logic            cmd_take;

  // colour register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_colour <= RESET_COLOUR;
    end else if (cfg_we) begin
      text_colour <= cfg_data;
    end
  end

  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .hold      (clearing),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  tcw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take),
    .text_colour (text_colour),
    .clearing    (clearing),
    .empty       (empty),
    .pop         (pop),
    .out_data    (out_data)
  );

`ifndef NO_ASSERTIONS
  // no item enters during the clearing pass after reset
  a_hold_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> full)
    else $error("item accepted during clearing pass");

  // a waiting result always shows an on-screen cursor
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_data.cursor_col < COL_W'(COLS)) &&
               (out_data.cursor_row < ROW_W'(ROWS)))
    else $error("cursor off screen");

  // linear position agrees with column and row
  a_linear_match: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_data.cursor_linear ==
               LIN_W'(linear(out_data.cursor_col, out_data.cursor_row)))
    else $error("cursor linear position mismatch");

  // the back end only takes work it has been offered
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid)
    else $error("command taken from empty queue");
`endif

endmodule

>>> tb/tb.sv
// tb: self-checking bench for text_console_writer_core (cursor, cells, colour)
// keeps its own screen store and cursor, predicts every result; uses tcw_pkg
module tb;
  import tcw_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES  = NCELLS + 2 * COLS + 50;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CH_W-1:0] cfg_data = '0;

  // screen store, cursor and colour as the block should hold them
  logic [15:0] shadow_cells [NCELLS];
  int shadow_col;
  int shadow_row;
  logic [CH_W-1:0] shadow_colour;

  out_t cursor_expect_q [$];
  int mismatch_count = 0;
  int stall_cycles = 0;
  bit tx_idle_en = 1'b1;
  bit rx_stall_en = 1'b1;
  bit long_hold_req = 1'b0;

  text_console_writer_core u_top (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic void fill_screen(input logic [15:0] fill_value);
    for (int i = 0; i < NCELLS; i++) shadow_cells[i] = fill_value;
  endfunction

  // next row, scrolling up one row when past the bottom
  function automatic void advance_line();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
      for (int i = 0; i < COLS; i++) shadow_cells[(ROWS - 1) * COLS + i] = {shadow_colour, CH_SPACE};
      shadow_row = ROWS - 1;
    end
  endfunction

  // apply one item to the shadow screen and return the cursor result it gives
  function automatic out_t console_predict(input in_t it);
    int c;
    int r;
    int pos;
    out_t res;
    c = (it.col > COLS - 1) ? COLS - 1 : int'(it.col);
    r = (it.row > ROWS - 1) ? ROWS - 1 : int'(it.row);
    res = '0;
    case (it.kind)
      KIND_PUT: begin
        pos = shadow_row * COLS + shadow_col;
        if (it.char_code == CH_NEWLINE) begin
          advance_line();
        end else if (it.char_code == CH_BACKSPACE) begin
          if (pos != 0) begin
            shadow_cells[pos - 1] = {shadow_colour, CH_SPACE};
            if (shadow_col == 0) begin
              shadow_row--;
              shadow_col = COLS - 1;
            end else begin
              shadow_col--;
            end
          end
        end else if (it.char_code == CH_ESCAPE) begin
          fill_screen({shadow_colour, CH_SPACE});
          shadow_col = 0;
          shadow_row = 0;
        end else begin
          shadow_cells[pos] = {shadow_colour, it.char_code};
          shadow_col++;
          if (shadow_col >= COLS) advance_line();
        end
      end
      KIND_READ: begin
        res.read_char = shadow_cells[r * COLS + c][7:0];
        res.read_attr = shadow_cells[r * COLS + c][15:8];
      end
      KIND_PLACE: begin
        shadow_col = c;
        shadow_row = r;
      end
      default: ;
    endcase
    res.cursor_col    = COL_W'(shadow_col);
    res.cursor_row    = ROW_W'(shadow_row);
    res.cursor_linear = LIN_W'(shadow_row * COLS + shadow_col);
    return res;
  endfunction

  // track reset, colour writes and accepted items
  always @(posedge clk) begin
    if (rst) begin
      shadow_colour = RESET_COLOUR;
      fill_screen({RESET_COLOUR, CH_SPACE});
      shadow_col = 0;
      shadow_row = 0;
    end else begin
      if (cfg_we) shadow_colour = cfg_data;
      if (push && !full) cursor_expect_q.push_back(console_predict(in_data));
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // compare each popped result with the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (!rst && pop && !empty) begin
      if (cursor_expect_q.size() == 0) begin
        $error("result popped with no item waiting");
        mismatch_count++;
      end else begin
        want = cursor_expect_q.pop_front();
        check_field("cursor_col", 16'(want.cursor_col), 16'(out_data.cursor_col));
        check_field("cursor_row", 16'(want.cursor_row), 16'(out_data.cursor_row));
        check_field("cursor_linear", 16'(want.cursor_linear),
                    16'(out_data.cursor_linear));
        check_field("read_char", 16'(want.read_char), 16'(out_data.read_char));
        check_field("read_attr", 16'(want.read_attr), 16'(out_data.read_attr));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (rx_stall_en && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic in_t mk(input logic [1:0] k, input logic [CH_W-1:0] ch,
                             input int c, input int r);
    in_t it;
    it.kind      = k;
    it.char_code = ch;
    it.col       = COL_W'(c);
    it.row       = ROW_W'(r);
    return it;
  endfunction

  // mostly in-range puts, reads and placements; some clamped, some unused kind
  function automatic in_t random_item();
    in_t it;
    int pick;
    int sel;
    it.char_code = CH_W'($urandom_range(0, 255));
    it.col = ($urandom_range(0, 99) < 85) ? COL_W'($urandom_range(0, COLS - 1))
                                          : COL_W'($urandom_range(0, 127));
    it.row = ($urandom_range(0, 99) < 85) ? ROW_W'($urandom_range(0, ROWS - 1))
                                          : ROW_W'($urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      it.kind = KIND_PUT;
      sel = $urandom_range(0, 99);
      if (sel < 4) it.char_code = CH_NEWLINE;
      else if (sel < 5) it.char_code = CH_ESCAPE;
      else if (sel < 10) it.char_code = CH_BACKSPACE;
    end else if (pick < 80) begin
      it.kind = KIND_READ;
      // half the reads look at the cursor row, where recent text sits
      if ($urandom_range(0, 1) == 1) it.row = ROW_W'(shadow_row);
    end else if (pick < 95) begin
      it.kind = KIND_PLACE;
    end else begin
      it.kind = KIND_UNUSED;
    end
    return it;
  endfunction

  task automatic sender_gap();
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // offer one item and hold it until the block takes it
  task automatic send_item(input in_t it);
    push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full !== 1'b0);
  endtask

  task automatic send_random(input int count);
    repeat (count) begin
      sender_gap();
      send_item(random_item());
    end
  endtask

  // stop offering and wait for every expected result
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    wait (cursor_expect_q.size() == 0);
    @(posedge clk);
  endtask

  // colour register only changes with the block idle
  task automatic write_colour(input logic [CH_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    send_item(mk(KIND_PUT, "H", 0, 0));
    send_item(mk(KIND_READ, 8'h00, 0, 0));
    send_item(mk(KIND_PUT, CH_BACKSPACE, 0, 0));
    // backspace with the cursor at the origin
    send_item(mk(KIND_PUT, CH_BACKSPACE, 0, 0));
    send_item(mk(KIND_PUT, 8'hFF, 0, 0));
    send_item(mk(KIND_PUT, 8'h00, 0, 0));
    send_item(mk(KIND_READ, 8'h00, 1, 0));
    send_item(mk(KIND_PUT, CH_NEWLINE, 0, 0));
    // backspace from column 0 wraps to the end of the row above
    send_item(mk(KIND_PLACE, 8'h00, 0, 3));
    send_item(mk(KIND_PUT, CH_BACKSPACE, 0, 0));
    send_item(mk(KIND_READ, 8'h00, COLS - 1, 2));
    // clamped placement, then a wrap on the bottom row scrolls
    send_item(mk(KIND_PLACE, 8'h00, 127, 31));
    send_item(mk(KIND_PUT, "Z", 0, 0));
    send_item(mk(KIND_READ, 8'h00, COLS - 1, ROWS - 2));
    send_item(mk(KIND_READ, 8'h00, 127, 31));
    // newline on the bottom row scrolls too
    send_item(mk(KIND_PUT, CH_NEWLINE, 0, 0));
    send_item(mk(KIND_READ, 8'h00, COLS - 1, ROWS - 3));
    send_item(mk(KIND_UNUSED, 8'hFF, 127, 31));
    send_item(mk(KIND_PUT, CH_ESCAPE, 0, 0));
    send_item(mk(KIND_READ, 8'h00, COLS - 1, ROWS - 3));
    // wrap off the last column of a row that is not the bottom
    send_item(mk(KIND_PLACE, 8'h00, COLS - 1, 0));
    send_item(mk(KIND_PUT, "q", 0, 0));
    send_item(mk(KIND_PUT, "r", 0, 0));
    send_item(mk(KIND_READ, 8'h00, COLS - 1, 0));
  endtask

  task automatic test_colour_settings();
    logic [CH_W-1:0] settings [4] = '{8'h00, 8'hFF, 8'h4E, 8'h81};
    foreach (settings[i]) begin
      write_colour(settings[i]);
      // a clear shows the new colour in every blank cell
      send_item(mk(KIND_PUT, CH_ESCAPE, 0, 0));
      send_random(70);
    end
  endtask

  task automatic test_random_text();
    send_random(1200);
  endtask

  task automatic test_result_backpressure();
    long_hold_req = 1'b1;
    tx_idle_en = 1'b0;
    send_random(40);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_sender_pause();
    send_random(60);
    drain_results();
    send_random(60);
  endtask

  task automatic test_streaming();
    tx_idle_en = 1'b0;
    rx_stall_en = 1'b0;
    send_random(150);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_colour_settings();
    test_random_text();
    test_result_backpressure();
    test_sender_pause();
    test_streaming();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
